// ----- src/vdag_pkg.sv -----
package vdag_pkg;

    // Frame geometry
    localparam int unsigned LINES_PER_FRAME = 256;
    localparam int unsigned SLOTS_PER_LINE  = 80;
    localparam int unsigned LINE_W  = 8;
    localparam int unsigned SLOT_W  = 7;
    localparam int unsigned ROW_W   = 4;
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned FETCH_W = 15;
    localparam int unsigned MODE_W  = 3;

    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(LINES_PER_FRAME - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS_PER_LINE - 1);
    // lines past this one are gaps in the ten-row modes
    localparam logic [LINE_W-1:0] LAST_SHOWN_LINE = 8'd249;
    localparam logic [ROW_W-1:0]  LAST_ROW_TEN    = 4'd9;
    localparam logic [ROW_W-1:0]  LAST_ROW_EIGHT  = 4'd7;
    localparam logic [ADDR_W-1:0] CELL_STEP       = 16'd8;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 1'b1;

    // Display modes with distinct behavior
    localparam logic [MODE_W-1:0] MODE_THREE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FOUR  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FIVE  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SIX   = 3'd6;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [SLOT_W-1:0] slot;
        logic [ROW_W-1:0]  row_ten;   // line number mod 10
        logic [ADDR_W-1:0] line_start;
        logic [ADDR_W-1:0] cur;
    } t_state;

    typedef struct packed {
        logic [FETCH_W-1:0] fetch_address;
        logic               blank_line;
        logic               line_end;
        logic               frame_end;
    } t_result;

    function automatic logic [ADDR_W-1:0] mode_base(input logic [MODE_W-1:0] m);
        logic [ADDR_W-1:0] b;
        unique case (m)
            MODE_THREE:           b = 16'h4000;
            MODE_FOUR, MODE_FIVE: b = 16'h5800;
            MODE_SIX:             b = 16'h6000;
            default:              b = 16'h3000;
        endcase
        return b;
    endfunction

    function automatic logic [ADDR_W-1:0] mode_wrap(input logic [MODE_W-1:0] m);
        logic [ADDR_W-1:0] w;
        unique case (m)
            MODE_THREE:           w = 16'h4000;
            MODE_FOUR, MODE_FIVE: w = 16'h2800;
            MODE_SIX:             w = 16'h2000;
            default:              w = 16'h5000;
        endcase
        return w;
    endfunction

endpackage

// ----- src/vdag_step.sv -----
module vdag_step (
    input  logic [vdag_pkg::MODE_W-1:0]  i_mode,
    input  logic [vdag_pkg::FETCH_W-1:0] i_start,
    input  logic                         i_restart,
    input  vdag_pkg::t_state             i_state,
    output vdag_pkg::t_state             o_state,
    output vdag_pkg::t_result            o_result
);

    logic                          w_load;
    logic [vdag_pkg::ADDR_W-1:0]   w_origin;
    vdag_pkg::t_state              w_s;
    logic                          w_tenrow;
    logic                          w_narrow;
    logic                          w_blank;
    logic                          w_hold;
    logic                          w_first;
    logic                          w_last;
    logic [vdag_pkg::ADDR_W-1:0]   w_cur_wrapped;
    logic [vdag_pkg::ADDR_W-1:0]   w_cur_next;
    logic                          w_lend;
    logic                          w_fend;
    logic                          w_row_last;
    logic [vdag_pkg::ADDR_W-1:0]   w_row_step;
    logic [vdag_pkg::ADDR_W-1:0]   w_ls_next;

    // Frame origin: start address with low bits dropped, mode base if zero
    assign w_origin = (i_start[14:6] == '0) ? vdag_pkg::mode_base(i_mode)
                                            : {1'b0, i_start[14:6], 6'b0};

    // Frame reload at line 0 slot 0 or on request
    assign w_load = i_restart || (i_state.line == '0 && i_state.slot == '0);

    always_comb begin
        w_s = i_state;
        if (w_load) begin
            w_s.line       = '0;
            w_s.slot       = '0;
            w_s.row_ten    = '0;
            w_s.line_start = w_origin;
            w_s.cur        = w_origin;
        end
    end

    // Mode decode and gap lines
    assign w_tenrow = (i_mode == vdag_pkg::MODE_THREE) || (i_mode == vdag_pkg::MODE_SIX);
    assign w_narrow = (i_mode == vdag_pkg::MODE_FOUR) || (i_mode == vdag_pkg::MODE_FIVE)
                   || (i_mode == vdag_pkg::MODE_SIX);
    assign w_blank  = w_tenrow && ((w_s.row_ten > vdag_pkg::LAST_ROW_EIGHT)
                   || (w_s.line > vdag_pkg::LAST_SHOWN_LINE));
    assign w_hold   = (i_mode == vdag_pkg::MODE_SIX) && w_blank;

    // Cell address: wrap on entry, step after the last slot of the cell
    assign w_first = !w_narrow || !w_s.slot[0];
    assign w_last  = !w_narrow ||  w_s.slot[0];
    assign w_cur_wrapped = (w_first && w_s.cur[15]) ? w_s.cur - vdag_pkg::mode_wrap(i_mode)
                                                    : w_s.cur;
    assign w_cur_next = (w_hold || !w_last) ? w_cur_wrapped : w_cur_wrapped + vdag_pkg::CELL_STEP;

    assign w_lend = (w_s.slot >= vdag_pkg::LAST_SLOT);
    assign w_fend = w_lend && (w_s.line >= vdag_pkg::LAST_LINE);

    // Row stride on the last pixel row of a character row
    assign w_row_last = (i_mode == vdag_pkg::MODE_THREE || i_mode == vdag_pkg::MODE_SIX)
                      ? ((i_mode == vdag_pkg::MODE_THREE) ? (w_s.row_ten == vdag_pkg::LAST_ROW_TEN)
                                                          : (w_s.row_ten == vdag_pkg::LAST_ROW_EIGHT))
                      : (w_s.line[2:0] == 3'd7);

    always_comb begin
        w_row_step = 16'd1;
        if (w_row_last) begin
            unique case (i_mode)
                vdag_pkg::MODE_THREE:                                         w_row_step = 16'd631;
                vdag_pkg::MODE_FOUR, vdag_pkg::MODE_FIVE, vdag_pkg::MODE_SIX: w_row_step = 16'd313;
                default:                                                      w_row_step = 16'd633;
            endcase
        end
    end

    assign w_ls_next = w_hold ? w_s.line_start : w_s.line_start + w_row_step;

    // Next counter state
    always_comb begin
        o_state = w_s;
        o_state.cur = w_hold ? w_s.cur : w_cur_next;
        if (w_lend) begin
            o_state.line_start = w_ls_next;
            o_state.cur        = w_ls_next;
            o_state.slot       = '0;
            if (w_fend) begin
                o_state.line    = '0;
                o_state.row_ten = '0;
            end else begin
                o_state.line    = w_s.line + 1'b1;
                o_state.row_ten = (w_s.row_ten >= vdag_pkg::LAST_ROW_TEN) ? '0
                                                                           : w_s.row_ten + 1'b1;
            end
        end else begin
            o_state.slot = w_s.slot + 1'b1;
        end
    end

    // Result word
    assign o_result.fetch_address = w_hold ? '0 : w_cur_wrapped[vdag_pkg::FETCH_W-1:0];
    assign o_result.blank_line    = w_blank;
    assign o_result.line_end      = w_lend;
    assign o_result.frame_end     = w_fend;

endmodule

// ----- src/video_display_address_generator.sv -----
// Results are registered in the main output register, or in the skid while the output stalls.
// One word is taken per cycle when not stalled; the counter update in vdag_step is combinational.
// A two-entry output register (main plus skid) takes a new word while a result is stalled.
// Reset (synchronous, active low) clears the counters and configuration to mode 0 and start 0,
// so the first accepted word starts a new frame.
module video_display_address_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [vdag_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vdag_pkg::FETCH_W-1:0]   i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_frame_restart,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [vdag_pkg::FETCH_W-1:0]   o_fetch_address,
    output logic                           o_blank_line,
    output logic                           o_line_end,
    output logic                           o_frame_end
);

    logic [vdag_pkg::MODE_W-1:0]  r_mode;
    logic [vdag_pkg::FETCH_W-1:0] r_start;
    vdag_pkg::t_state             r_state;
    vdag_pkg::t_state             n_state;
    vdag_pkg::t_result            n_result;
    vdag_pkg::t_result            r_out;
    vdag_pkg::t_result            r_skid;
    logic                         r_out_valid;
    logic                         r_skid_valid;
    logic                         w_in_acc;
    logic                         w_out_fire;
    logic                         w_out_free;

    assign w_in_acc   = i_in_valid && !r_skid_valid;
    assign w_out_fire = r_out_valid && !i_out_stall;
    assign w_out_free = w_out_fire || !r_out_valid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_start <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                vdag_pkg::CFG_SCREEN_MODE:   r_mode  <= i_cfg_data[vdag_pkg::MODE_W-1:0];
                vdag_pkg::CFG_START_ADDRESS: r_start <= i_cfg_data;
                default:                     r_start <= r_start;
            endcase
        end
    end

    vdag_step u_step (
        .i_mode    (r_mode),
        .i_start   (r_start),
        .i_restart (i_frame_restart),
        .i_state   (r_state),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    // Counter state, advanced once per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.line       <= '0;
            r_state.slot       <= '0;
            r_state.row_ten    <= '0;
            r_state.line_start <= vdag_pkg::mode_base('0);
            r_state.cur        <= vdag_pkg::mode_base('0);
        end else if (w_in_acc) begin
            r_state <= n_state;
        end
    end

    // Output and skid valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid || w_in_acc;
            r_skid_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output and skid payload
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_in_acc) begin
                r_out <= n_result;
            end
        end else if (w_in_acc) begin
            r_skid <= n_result;
        end
    end

    assign o_in_stall      = r_skid_valid;
    assign o_out_valid     = r_out_valid;
    assign o_fetch_address = r_out.fetch_address;
    assign o_blank_line    = r_out.blank_line;
    assign o_line_end      = r_out.line_end;
    assign o_frame_end     = r_out.frame_end;

    // Checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.slot <= vdag_pkg::LAST_SLOT)
        else $error("slot counter past end of line");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.row_ten <= vdag_pkg::LAST_ROW_TEN)
        else $error("row counter out of range");

    a_frame_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && n_result.frame_end) |=> (r_state.line == '0 && r_state.slot == '0))
        else $error("counters did not return to frame start");

    a_fend_lend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_end) |-> r_out.line_end)
        else $error("frame end without line end");

endmodule
